>>> rtl/core/rart_pkg.sv
`default_nettype none
package rart_pkg;
  localparam int MaxRegions = 16;
  localparam int IdxW = $clog2(MaxRegions);
  localparam int CntW = $clog2(MaxRegions + 1);
  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_FIN = 2'd1;
  localparam logic [1:0] KIND_LOOK = 2'd2;
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic add;
    logic fin_start;
    logic sort_step;
    logic base_step;
    logic fin_done;
    logic look;
  } rart_cmd_t;

  typedef struct packed {
    logic sort_done;
    logic base_done;
    logic full;
  } rart_sts_t;
endpackage
`default_nettype wire

>>> rtl/core/rart_ctrl.sv
`default_nettype none
module rart_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       in_kind,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output rart_pkg::rart_cmd_t   cmd,
  input  wire rart_pkg::rart_sts_t sts
);
  import rart_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SORT = 2'd1;
  localparam logic [1:0] S_BASE = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic acc;

  assign acc = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_kind == KIND_FIN) begin
            cmd.fin_start = 1'b1;
            state_nxt = S_SORT;
          end else begin
            cmd.add = (in_kind == KIND_ADD);
            cmd.look = 1'b1;
            state_nxt = S_OUT;
          end
        end
      end
      S_SORT: begin
        cmd.sort_step = 1'b1;
        if (sts.sort_done) state_nxt = S_BASE;
      end
      S_BASE: begin
        if (sts.base_done) begin
          cmd.fin_done = 1'b1;
          state_nxt = S_OUT;
        end else cmd.base_step = 1'b1;
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

>>> rtl/core/rart_dp.sv
`default_nettype none
module rart_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rart_pkg::rart_cmd_t cmd,
  output rart_pkg::rart_sts_t      sts,
  input  wire logic [1:0]          in_kind,
  input  wire logic [31:0]         in_region_start,
  input  wire logic [31:0]         in_region_end,
  input  wire logic [31:0]         in_region_length,
  input  wire logic [31:0]         in_lookup_address,
  output logic [31:0]              out_mapped_address,
  output logic                     out_hit,
  output logic [31:0]              out_total_size,
  output logic [31:0]              out_lowest_start,
  output logic                     out_status
);
  import rart_pkg::*;
  logic [31:0] st_r [MaxRegions];
  logic [31:0] en_r [MaxRegions];
  logic [31:0] sz_r [MaxRegions];
  logic [31:0] bs_r [MaxRegions];
  logic [CntW-1:0] cnt_r;
  logic [31:0] total_r, first_r, acc_r;
  logic [CntW-1:0] pos_r;
  logic swapped_r;
  logic [31:0] map_r;
  logic hit_r, status_r;

  logic [MaxRegions-1:0] match;
  logic [31:0] map_c;
  logic hit_c;
  logic [IdxW-1:0] pidx;
  logic pass_end, do_swap;

  assign sts.full = (cnt_r == CntW'(MaxRegions));
  assign pass_end = (32'(pos_r) + 32'd1 >= 32'(cnt_r));
  assign pidx = pos_r[IdxW-1:0];
  assign do_swap = !pass_end && (st_r[pidx] > st_r[pidx + IdxW'(1)]);
  assign sts.sort_done = pass_end && !swapped_r;
  assign sts.base_done = (pos_r >= cnt_r);

  always_comb begin
    for (int i = 0; i < MaxRegions; i++)
      match[i] = (CntW'(i) < cnt_r) && (st_r[i] <= in_lookup_address)
                 && (en_r[i] > in_lookup_address);
    map_c = MISS_VALUE;
    hit_c = 1'b0;
    for (int i = MaxRegions - 1; i >= 0; i--)
      if (match[i]) begin
        map_c = bs_r[i] + (in_lookup_address - st_r[i]);
        hit_c = 1'b1;
      end
  end

  always_ff @(posedge clk) begin
    if (cmd.add && !sts.full) begin
      st_r[cnt_r[IdxW-1:0]] <= in_region_start;
      en_r[cnt_r[IdxW-1:0]] <= in_region_end;
      sz_r[cnt_r[IdxW-1:0]] <= in_region_length;
      bs_r[cnt_r[IdxW-1:0]] <= '0;
    end
    if (cmd.sort_step && do_swap) begin
      st_r[pidx] <= st_r[pidx + IdxW'(1)];
      en_r[pidx] <= en_r[pidx + IdxW'(1)];
      sz_r[pidx] <= sz_r[pidx + IdxW'(1)];
      st_r[pidx + IdxW'(1)] <= st_r[pidx];
      en_r[pidx + IdxW'(1)] <= en_r[pidx];
      sz_r[pidx + IdxW'(1)] <= sz_r[pidx];
    end
    if (cmd.base_step) bs_r[pidx] <= acc_r;
    if (cmd.look) begin
      map_r <= (in_kind == KIND_LOOK) ? map_c : MISS_VALUE;
      hit_r <= (in_kind == KIND_LOOK) && hit_c;
      status_r <= cmd.add && sts.full;
    end
    if (cmd.fin_start) begin
      map_r <= MISS_VALUE;
      hit_r <= 1'b0;
      status_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      total_r <= '0;
      first_r <= '0;
      pos_r <= '0;
      swapped_r <= 1'b0;
      acc_r <= '0;
    end else begin
      if (cmd.add && !sts.full) cnt_r <= cnt_r + CntW'(1);
      if (cmd.fin_start) begin
        pos_r <= '0;
        swapped_r <= 1'b0;
        acc_r <= '0;
      end
      if (cmd.sort_step) begin
        if (pass_end) begin
          pos_r <= '0;
          swapped_r <= 1'b0;
        end else begin
          pos_r <= pos_r + CntW'(1);
          if (do_swap) swapped_r <= 1'b1;
        end
      end
      if (cmd.base_step) begin
        acc_r <= acc_r + sz_r[pidx];
        pos_r <= pos_r + CntW'(1);
      end
      if (cmd.fin_done) begin
        total_r <= acc_r;
        first_r <= (cnt_r != '0) ? st_r[0] : '0;
      end
    end
  end

  assign out_mapped_address = map_r;
  assign out_hit = hit_r;
  assign out_total_size = total_r;
  assign out_lowest_start = first_r;
  assign out_status = status_r;
endmodule
`default_nettype wire

>>> rtl/core/region_address_remap_table.sv
// add, lookup and unused kinds give their registered result in the cycle after the transfer
// finalize: adjacent-swap sort passes over the table then one base per entry;
// one item in flight at a time
// add and lookup: a new item is taken only once the last result has left; lookup uses parallel comparators
// reset: synchronous active low, clears count, totals and control; table contents unset
`default_nettype none
module region_address_remap_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_region_start,
  input  wire logic [31:0] in_region_end,
  input  wire logic [31:0] in_region_length,
  input  wire logic [31:0] in_lookup_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_mapped_address,
  output logic             out_hit,
  output logic [31:0]      out_total_size,
  output logic [31:0]      out_lowest_start,
  output logic             out_status
);
  import rart_pkg::*;
  rart_cmd_t cmd;
  rart_sts_t sts;

  rart_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts)
  );

  rart_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_kind(in_kind),
    .in_region_start(in_region_start), .in_region_end(in_region_end),
    .in_region_length(in_region_length), .in_lookup_address(in_lookup_address),
    .out_mapped_address(out_mapped_address), .out_hit(out_hit),
    .out_total_size(out_total_size), .out_lowest_start(out_lowest_start),
    .out_status(out_status)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_hit_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_mapped_address == MISS_VALUE))
    else $error("miss without miss value");
  a_status_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_status)) else $error("hit and full together");
endmodule
`default_nettype wire
